// ===== hw/rtl/wavefront_slope_classifier_top_defines.svh =====
// Assertion macros used by the wavefront slope classifier top level.
// Bodies are empty when SYNTHESIS is defined.
`ifndef WAVEFRONT_SLOPE_CLASSIFIER_TOP_DEFINES_SVH
`define WAVEFRONT_SLOPE_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WSC_ASSERT(lbl, c, r, prop, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);
`define WSC_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) ante |=> cons) else $error(msg);
`else
`define WSC_ASSERT(lbl, c, r, prop, msg)
`define WSC_ASSERT_NEXT(lbl, c, r, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/wsc_pkg.sv =====
// Shared constants, widths and helper functions of the slope classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wsc_pkg;
	localparam int MAX_COLS    = 2048;
	localparam int COL_BITS    = $clog2(MAX_COLS);
	localparam int LW_BITS     = 12;
	localparam int HEIGHT_BITS = 24;
	localparam int SCALE_BITS  = 24;
	localparam int BOUND_BITS  = 24;
	localparam int SLOPE_BITS  = 23;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int DIFF_BITS   = HEIGHT_BITS + 1;
	localparam int T_BITS      = DIFF_BITS + SCALE_BITS;
	localparam int CORDIC_W    = T_BITS + 3;
	localparam int Z_BITS      = 32;
	localparam int CORDIC_STEPS = 28;
	localparam int STEP_BITS   = 5;
	localparam int ARC_BITS    = 22;
	localparam int PROD_BITS   = Z_BITS - 1 + ARC_BITS;
	localparam int SQ_BITS     = 2 * SLOPE_BITS;
	localparam int SQ_IN_BITS  = SQ_BITS + 1;
	localparam int ROOT_STEPS  = (SQ_IN_BITS + 1) / 2;
	localparam int ROOT_BITS   = ROOT_STEPS;
	localparam int RSTEP_BITS  = $clog2(ROOT_STEPS + 1);

	localparam logic [ARC_BITS-1:0]        ARCSEC_Q4_PER_RAD = 22'd3300240;
	localparam logic [SLOPE_BITS-1:0]      MAG_MAX = {SLOPE_BITS{1'b1}};
	localparam logic signed [CORDIC_W-1:0] X_INIT = CORDIC_W'(64'h1_0000_0000);
	localparam logic [PROD_BITS:0]         ROUND_HALF = (PROD_BITS + 1)'(64'h2000_0000);
	localparam logic [SQ_IN_BITS-1:0]      ROOT_BIT0 = SQ_IN_BITS'(1) << (2 * (ROOT_STEPS - 1));

	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_SCALE = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_BOUND = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_BOUND = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE_LIMIT = 3'd4;

	localparam logic [1:0] BAND_IN     = 2'd0;
	localparam logic [1:0] BAND_HIGH   = 2'd1;
	localparam logic [1:0] BAND_LOW    = 2'd2;
	localparam logic [1:0] BAND_MASKED = 2'd3;

	function automatic logic [29:0] atan_q30(input logic [STEP_BITS-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000008;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] band_of(
		input logic signed [HEIGHT_BITS-1:0] h,
		input logic                          m,
		input logic signed [BOUND_BITS-1:0]  ub,
		input logic signed [BOUND_BITS-1:0]  lb
	);
		logic [1:0] b;
		if (!m)
			b = BAND_MASKED;
		else if (h > ub)
			b = BAND_HIGH;
		else if (h < lb)
			b = BAND_LOW;
		else
			b = BAND_IN;
		return b;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/wsc_ram.sv =====
// Generic single-port synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wsc_slope.sv =====
// Slope unit: |d| * scale, 28-step vectoring CORDIC, radians to Q19.4 arcsec.
// Depends on wsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsc_slope (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [wsc_pkg::DIFF_BITS-1:0] diff,
	input  wire logic        [wsc_pkg::SCALE_BITS-1:0] scale,
	output logic                                      done,
	output logic             [wsc_pkg::SLOPE_BITS-1:0] slope
);
	typedef enum logic [4:0] {
		SL_IDLE = 5'b00001,
		SL_MUL  = 5'b00010,
		SL_ITER = 5'b00100,
		SL_ARC  = 5'b01000,
		SL_RND  = 5'b10000
	} sl_state_t;

	sl_state_t                                 state_q;
	logic [wsc_pkg::DIFF_BITS-1:0]             dabs_q;
	logic signed [wsc_pkg::CORDIC_W-1:0]       x_q, y_q, xs, ys;
	logic signed [wsc_pkg::Z_BITS-1:0]         z_q, at;
	logic [wsc_pkg::STEP_BITS-1:0]             i_q;
	logic                                      tz_q;
	logic [wsc_pkg::Z_BITS-2:0]                zc;
	logic [wsc_pkg::PROD_BITS-1:0]             prod_q;
	logic [wsc_pkg::PROD_BITS:0]               rnd;
	logic [wsc_pkg::T_BITS-1:0]                t;

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign at  = signed'({2'b00, wsc_pkg::atan_q30(i_q)});
	assign zc  = z_q[wsc_pkg::Z_BITS-1] ? '0 : z_q[wsc_pkg::Z_BITS-2:0];
	assign rnd = {1'b0, prod_q} + wsc_pkg::ROUND_HALF;
	assign t   = dabs_q * scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SL_IDLE;
			done    <= 1'b0;
			i_q     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				SL_IDLE: begin
					if (start)
						state_q <= SL_MUL;
				end
				SL_MUL: begin
					i_q     <= '0;
					state_q <= SL_ITER;
				end
				SL_ITER: begin
					i_q <= i_q + 1'b1;
					if (i_q == wsc_pkg::STEP_BITS'(wsc_pkg::CORDIC_STEPS - 1))
						state_q <= SL_ARC;
				end
				SL_ARC: state_q <= SL_RND;
				SL_RND: begin
					done    <= 1'b1;
					state_q <= SL_IDLE;
				end
				default: state_q <= SL_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SL_IDLE: begin
				if (start)
					dabs_q <= diff[wsc_pkg::DIFF_BITS-1] ? unsigned'(-diff) : unsigned'(diff);
			end
			SL_MUL: begin
				x_q  <= wsc_pkg::X_INIT;
				y_q  <= signed'({3'b000, t});
				z_q  <= '0;
				tz_q <= (t == '0);
			end
			SL_ITER: begin
				if (!y_q[wsc_pkg::CORDIC_W-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			SL_ARC: prod_q <= zc * wsc_pkg::ARCSEC_Q4_PER_RAD;
			SL_RND: slope <= tz_q ? '0 : rnd[wsc_pkg::PROD_BITS-1:30];
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wsc_sqrt.sv =====
// Rounded integer square root, two input bits per cycle, saturated output.
// Depends on wsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsc_sqrt (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [wsc_pkg::SQ_IN_BITS-1:0]       s,
	output logic                                      done,
	output logic      [wsc_pkg::SLOPE_BITS-1:0]       root
);
	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_RUN  = 3'b010,
		SQ_RND  = 3'b100
	} sq_state_t;

	sq_state_t                       state_q;
	logic [wsc_pkg::SQ_IN_BITS-1:0]  v_q, r_q, bit_q;
	logic [wsc_pkg::SQ_IN_BITS:0]    rb;
	logic [wsc_pkg::RSTEP_BITS-1:0]  n_q;
	logic [wsc_pkg::ROOT_BITS:0]     rr;

	assign rb = {1'b0, r_q} + {1'b0, bit_q};
	assign rr = {1'b0, r_q[wsc_pkg::ROOT_BITS-1:0]} + (wsc_pkg::ROOT_BITS + 1)'(v_q > r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			done    <= 1'b0;
			n_q     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				SQ_IDLE: begin
					n_q <= '0;
					if (start)
						state_q <= SQ_RUN;
				end
				SQ_RUN: begin
					n_q <= n_q + 1'b1;
					if (n_q == wsc_pkg::RSTEP_BITS'(wsc_pkg::ROOT_STEPS - 1))
						state_q <= SQ_RND;
				end
				SQ_RND: begin
					done    <= 1'b1;
					state_q <= SQ_IDLE;
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					v_q   <= s;
					r_q   <= '0;
					bit_q <= wsc_pkg::ROOT_BIT0;
				end
			end
			SQ_RUN: begin
				if ({1'b0, v_q} >= rb) begin
					v_q <= v_q - rb[wsc_pkg::SQ_IN_BITS-1:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			SQ_RND: begin
				root <= (rr > (wsc_pkg::ROOT_BITS + 1)'(wsc_pkg::MAG_MAX)) ?
					wsc_pkg::MAG_MAX : rr[wsc_pkg::SLOPE_BITS-1:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wavefront_slope_classifier_top.sv =====
// Top level: line memory sequencer, config registers, output register.
// Depends on wsc_pkg, wsc_ram, wsc_slope, wsc_sqrt and the defines header.
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata height, tuser {last_row,in_mask}
// m_axis    out  m_axis_tvalid/tready       tdata slope_mag, tuser {over_limit,band}, tlast
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One pixel at a time: a first-row pixel only reads and writes the line memory;
// pixels of other rows also run two slope passes (28-step CORDIC) and the root
// start and wait in series, and a last-row pixel also emits its own result.
// The line memory is read twice and written once per pixel on one port.
// arst_n clears control; line memory contents are unknown until written.
// A held result in the output register does not block the next pixel beat;
// an emit state waits while a result is held and m_axis_tready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "wavefront_slope_classifier_top_defines.svh"
module wavefront_slope_classifier_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [23:0]                         s_axis_tdata,  // [23:0] height
	input  wire logic [1:0]                          s_axis_tuser,  // [0] in_mask, [1] last_row
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic      [23:0]                         m_axis_tdata,  // [22:0] slope_mag
	output logic      [2:0]                          m_axis_tuser,  // [1:0] band, [2] over_limit
	output logic                                     m_axis_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [wsc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [wsc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	localparam int H = wsc_pkg::HEIGHT_BITS;
	localparam int C = wsc_pkg::COL_BITS;

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b000000000001,
		ST_RD1       = 12'b000000000010,
		ST_WR        = 12'b000000000100,
		ST_GX_GO     = 12'b000000001000,
		ST_GX_WAIT   = 12'b000000010000,
		ST_GY_GO     = 12'b000000100000,
		ST_GY_WAIT   = 12'b000001000000,
		ST_SQR       = 12'b000010000000,
		ST_ROOT_GO   = 12'b000100000000,
		ST_ROOT_WAIT = 12'b001000000000,
		ST_EMIT_A    = 12'b010000000000,
		ST_EMIT_B    = 12'b100000000000
	} st_t;

	st_t state_q;

	logic [wsc_pkg::LW_BITS-1:0]           line_width_q, lw_eff, wm1;
	logic [wsc_pkg::SCALE_BITS-1:0]        angle_scale_q;
	logic signed [wsc_pkg::BOUND_BITS-1:0] upper_bound_q, lower_bound_q;
	logic [wsc_pkg::SLOPE_BITS-1:0]        slope_limit_q;

	logic [C-1:0]        col_q;
	logic                first_row_q;
	logic signed [H-1:0] h_q, ph_q, nh_q;
	logic                m_q, lr_q, last_q, fr_q, pm_q, nm_q;
	logic [wsc_pkg::SLOPE_BITS-1:0] gx_q, gy_q, mag_q;
	logic [wsc_pkg::SQ_BITS-1:0]    gx2_q, gy2_q;

	logic                 in_acc, out_load, out_valid_q;
	logic [wsc_pkg::SLOPE_BITS-1:0] out_mag_q, out_mag_d;
	logic [1:0]           out_band_q, out_band_d;
	logic                 out_over_q, out_over_d, out_fe_q, out_fe_d;

	logic                 ram_we;
	logic [C-1:0]         ram_addr;
	logic [H:0]           ram_rdata;

	logic                 sl_start, sl_done;
	logic signed [wsc_pkg::DIFF_BITS-1:0] sl_diff;
	logic [wsc_pkg::SLOPE_BITS-1:0] sl_slope;
	logic                 root_start, root_done;
	logic [wsc_pkg::SLOPE_BITS-1:0] root;
	logic                 slopes_on;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign lw_eff = (line_width_q < wsc_pkg::LW_BITS'(2)) ? wsc_pkg::LW_BITS'(2) :
		(line_width_q > wsc_pkg::LW_BITS'(wsc_pkg::MAX_COLS)) ?
		wsc_pkg::LW_BITS'(wsc_pkg::MAX_COLS) : line_width_q;
	assign wm1 = lw_eff - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q  <= wsc_pkg::LW_BITS'(wsc_pkg::MAX_COLS);
			angle_scale_q <= 24'd65536;
			upper_bound_q <= '0;
			lower_bound_q <= '0;
			slope_limit_q <= 23'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wsc_pkg::REG_LINE_WIDTH:  line_width_q  <= cfg_data[wsc_pkg::LW_BITS-1:0];
				wsc_pkg::REG_ANGLE_SCALE: angle_scale_q <= cfg_data;
				wsc_pkg::REG_UPPER_BOUND: upper_bound_q <= signed'(cfg_data);
				wsc_pkg::REG_LOWER_BOUND: lower_bound_q <= signed'(cfg_data);
				wsc_pkg::REG_SLOPE_LIMIT: slope_limit_q <= cfg_data[wsc_pkg::SLOPE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ram_addr = col_q;
		if (state_q == ST_RD1)
			ram_addr = col_q + 1'b1;
	end
	assign ram_we = (state_q == ST_WR);

	wsc_ram #(
		.WIDTH(H + 1),
		.DEPTH(wsc_pkg::MAX_COLS)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({m_q, h_q}),
		.rdata (ram_rdata)
	);

	assign sl_start = (state_q == ST_GX_GO) || (state_q == ST_GY_GO);
	assign sl_diff  = (state_q == ST_GX_GO) ? ({ph_q[H-1], ph_q} - {nh_q[H-1], nh_q}) :
		({ph_q[H-1], ph_q} - {h_q[H-1], h_q});

	wsc_slope u_slope (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sl_start),
		.diff   (sl_diff),
		.scale  (angle_scale_q),
		.done   (sl_done),
		.slope  (sl_slope)
	);

	assign root_start = (state_q == ST_ROOT_GO);

	wsc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.s      ({1'b0, gx2_q} + {1'b0, gy2_q}),
		.done   (root_done),
		.root   (root)
	);

	assign slopes_on = pm_q && !last_q;

	always_comb begin
		out_load  = 1'b0;
		out_mag_d = mag_q;
		out_band_d = wsc_pkg::band_of(ph_q, pm_q, upper_bound_q, lower_bound_q);
		out_over_d = pm_q && (mag_q > slope_limit_q);
		out_fe_d   = 1'b0;
		if (state_q == ST_EMIT_A) begin
			out_load = !out_valid_q || m_axis_tready;
		end else if (state_q == ST_EMIT_B) begin
			out_load   = !out_valid_q || m_axis_tready;
			out_mag_d  = '0;
			out_band_d = wsc_pkg::band_of(h_q, m_q, upper_bound_q, lower_bound_q);
			out_over_d = 1'b0;
			out_fe_d   = last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			first_row_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_RD1;
				end
				ST_RD1: state_q <= ST_WR;
				ST_WR: begin
					if (last_q) begin
						col_q       <= '0;
						first_row_q <= lr_q;
					end else begin
						col_q <= col_q + 1'b1;
					end
					if (!fr_q)
						state_q <= ST_GX_GO;
					else if (lr_q)
						state_q <= ST_EMIT_B;
					else
						state_q <= ST_IDLE;
				end
				ST_GX_GO: state_q <= ST_GX_WAIT;
				ST_GX_WAIT: begin
					if (sl_done)
						state_q <= ST_GY_GO;
				end
				ST_GY_GO: state_q <= ST_GY_WAIT;
				ST_GY_WAIT: begin
					if (sl_done)
						state_q <= ST_SQR;
				end
				ST_SQR: state_q <= ST_ROOT_GO;
				ST_ROOT_GO: state_q <= ST_ROOT_WAIT;
				ST_ROOT_WAIT: begin
					if (root_done)
						state_q <= ST_EMIT_A;
				end
				ST_EMIT_A: begin
					if (out_load)
						state_q <= lr_q ? ST_EMIT_B : ST_IDLE;
				end
				ST_EMIT_B: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			h_q    <= signed'(s_axis_tdata[H-1:0]);
			m_q    <= s_axis_tuser[0];
			lr_q   <= s_axis_tuser[1];
			last_q <= ({1'b0, col_q} >= wm1);
			fr_q   <= first_row_q;
		end
		if (state_q == ST_RD1) begin
			ph_q <= signed'(ram_rdata[H-1:0]);
			pm_q <= ram_rdata[H];
		end
		if (state_q == ST_WR) begin
			nh_q <= signed'(ram_rdata[H-1:0]);
			nm_q <= ram_rdata[H];
		end
		if (state_q == ST_GX_WAIT && sl_done)
			gx_q <= (slopes_on && nm_q) ? sl_slope : '0;
		if (state_q == ST_GY_WAIT && sl_done)
			gy_q <= (slopes_on && m_q) ? sl_slope : '0;
		if (state_q == ST_SQR) begin
			gx2_q <= gx_q * gx_q;
			gy2_q <= gy_q * gy_q;
		end
		if (state_q == ST_ROOT_WAIT && root_done)
			mag_q <= pm_q ? root : '0;
		if (out_load) begin
			out_mag_q  <= out_mag_d;
			out_band_q <= out_band_d;
			out_over_q <= out_over_d;
			out_fe_q   <= out_fe_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_mag_q};
	assign m_axis_tuser  = {out_over_q, out_band_q};
	assign m_axis_tlast  = out_fe_q;

	`WSC_ASSERT(a_no_overwrite, clk, arst_n, out_load |-> (!out_valid_q || m_axis_tready), "result overwritten")
	`WSC_ASSERT_NEXT(a_accept_reads, clk, arst_n, in_acc, state_q == ST_RD1, "accept did not start line read")
	`WSC_ASSERT(a_root_state, clk, arst_n, root_done |-> (state_q == ST_ROOT_WAIT), "stray root done")
	`WSC_ASSERT(a_slope_state, clk, arst_n, sl_done |-> (state_q == ST_GX_WAIT || state_q == ST_GY_WAIT), "stray slope done")
endmodule
`default_nettype wire
